// ===== rtl/fpam_pkg.sv =====
// Shared types and constants for the single-precision add/multiply unit.
package fpam_pkg;

  localparam logic FUNC_ADD = 1'b0;
  localparam logic FUNC_MUL = 1'b1;
  localparam logic [9:0] EXP_BIAS = 10'd127;
  localparam int SIGN_POS = 31;

  typedef struct packed {
    logic        func;
    logic [31:0] operand_a;
    logic [31:0] operand_b;
  } fpam_in_t;

  typedef struct packed {
    logic [31:0] result_bits;
    logic        exponent_range_error;
  } fpam_out_t;

endpackage

// ===== rtl/float32_add_multiply_unit.sv =====
// Top level of the pipelined single-precision add/multiply unit.
//
// Accepts one request per cycle (busy is held low: the unit never stalls) and
// returns each result on out_valid for one cycle. The pipeline has four
// register stages: operand decode and alignment, significand add or subtract
// or product sum, leading-zero count, normalise and pack. The 24x24 product
// uses two 24x12 partial products in stage one that are summed in stage two.
// Rounding is truncation; infinities, NaNs and subnormals get no special
// handling; an exponent leaving 0..255 raises exponent_range_error and keeps
// the exponent modulo 256.
module float32_add_multiply_unit
  import fpam_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  fpam_in_t  in_req,
  output logic      out_valid,
  output fpam_out_t out_res
);

  // Stage 1: decode, order magnitudes, align, partial products.
  logic        v1_r;
  logic        mul1_r, pass1_r, zero1_r, sub1_r, sign1_r;
  logic [31:0] pass_val1_r;
  logic [9:0]  exp1_r;
  logic [23:0] ml1_r, ms1_r;
  logic [35:0] pp_lo1_r, pp_hi1_r;

  logic [31:0] a, b, big, little;
  logic [7:0]  el, es, d;
  logic [23:0] ma, mb, ml, ms_al;
  always_comb begin
    a = in_req.operand_a;
    b = in_req.operand_b;
    if (a[30:0] >= b[30:0]) begin
      big = a; little = b;
    end else begin
      big = b; little = a;
    end
    el = big[30:23];
    es = little[30:23];
    d  = el - es;
    ml = {1'b1, big[22:0]};
    ms_al = (d >= 8'd24) ? 24'd0 : ({1'b1, little[22:0]} >> d[4:0]);
    ma = {1'b1, a[22:0]};
    mb = {1'b1, b[22:0]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else        v1_r <= start;
    mul1_r <= in_req.func == FUNC_MUL;
    pp_lo1_r <= ma * mb[11:0];
    pp_hi1_r <= ma * mb[23:12];
    if (in_req.func == FUNC_MUL) begin
      zero1_r  <= (a == 32'd0) || (b == 32'd0);
      pass1_r  <= 1'b0;
      sign1_r  <= a[SIGN_POS] ^ b[SIGN_POS];
      exp1_r   <= {2'b00, a[30:23]} + {2'b00, b[30:23]} - EXP_BIAS;
      sub1_r   <= 1'b0;
    end else begin
      zero1_r  <= (a != 32'd0) && (b != 32'd0) && (a[31] != b[31])
                  && (a[30:0] == b[30:0]);
      pass1_r  <= (a == 32'd0) || (b == 32'd0);
      sign1_r  <= big[SIGN_POS];
      exp1_r   <= {2'b00, el};
      sub1_r   <= a[31] != b[31];
    end
    pass_val1_r <= (a == 32'd0) ? b : a;
    ml1_r <= ml;
    ms1_r <= ms_al;
  end

  // Stage 2: significand add/subtract or product sum.
  logic        v2_r, mul2_r, pass2_r, zero2_r, sign2_r;
  logic [31:0] pass_val2_r;
  logic [9:0]  exp2_r;
  logic [24:0] sum2_r;
  logic [47:0] prod2_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else        v2_r <= v1_r;
    mul2_r <= mul1_r; pass2_r <= pass1_r; zero2_r <= zero1_r;
    sign2_r <= sign1_r; pass_val2_r <= pass_val1_r; exp2_r <= exp1_r;
    sum2_r <= sub1_r ? ({1'b0, ml1_r} - {1'b0, ms1_r})
                     : ({1'b0, ml1_r} + {1'b0, ms1_r});
    prod2_r <= {12'd0, pp_lo1_r} + {pp_hi1_r, 12'd0};
  end

  // Stage 3: pick significand, count leading zeros.
  // A product reaching bit 47 is placed so that stage 4 drops one bit and
  // raises the exponent, as for an add carry.
  logic        v3_r, pass3_r, zero3_r, sign3_r, mul3_r;
  logic [31:0] pass_val3_r;
  logic [9:0]  exp3_r;
  logic [24:0] sig3_r;
  logic [4:0]  lz3_r;
  logic [24:0] sig_nxt;
  logic [4:0]  lz_nxt;
  always_comb begin
    if (mul2_r) sig_nxt = prod2_r[47] ? {prod2_r[47:24], 1'b0} : {1'b0, prod2_r[46:23]};
    else        sig_nxt = sum2_r;
    lz_nxt = 5'd0;
    for (int i = 0; i < 24; i++) begin
      if (sig_nxt[i]) lz_nxt = 5'(23 - i);
    end
  end
  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else        v3_r <= v2_r;
    pass3_r <= pass2_r; zero3_r <= zero2_r; sign3_r <= sign2_r;
    mul3_r <= mul2_r; pass_val3_r <= pass_val2_r; exp3_r <= exp2_r;
    sig3_r <= sig_nxt; lz3_r <= lz_nxt;
  end

  // Stage 4: normalise and pack.
  logic      v4_r;
  fpam_out_t res4_r;
  logic [9:0]  e_n;
  logic [23:0] m_n;
  always_comb begin
    if (sig3_r[24]) begin
      m_n = sig3_r[24:1];
      e_n = exp3_r + 10'd1;
    end else if (mul3_r) begin
      m_n = sig3_r[23:0];
      e_n = exp3_r;
    end else begin
      m_n = sig3_r[23:0] << lz3_r;
      e_n = exp3_r - {5'd0, lz3_r};
    end
  end
  always_ff @(posedge clk) begin
    if (!rst_n) v4_r <= 1'b0;
    else        v4_r <= v3_r;
    if (pass3_r) begin
      res4_r.result_bits <= pass_val3_r;
      res4_r.exponent_range_error <= 1'b0;
    end else if (zero3_r) begin
      res4_r.result_bits <= 32'd0;
      res4_r.exponent_range_error <= 1'b0;
    end else begin
      res4_r.result_bits <= {sign3_r, e_n[7:0], m_n[22:0]};
      res4_r.exponent_range_error <= e_n[9] | e_n[8];
    end
  end

  assign busy      = 1'b0;
  assign out_valid = v4_r;
  assign out_res   = res4_r;

endmodule

// ===== rtl/fpam_checker.sv =====
// Port-level assertions for the add/multiply unit, bound to the top level.
module fpam_checker
  import fpam_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input fpam_in_t  in_req,
  input logic      out_valid,
  input fpam_out_t out_res
);
  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |-> ##4 out_valid) else $error("result missing");
  a_none: assert property (@(posedge clk) disable iff (!rst_n)
    !(start && !busy) |-> ##4 !out_valid) else $error("result invented");
  a_mzero: assert property (@(posedge clk) disable iff (!rst_n)
    start && in_req.func == FUNC_MUL && in_req.operand_a == 32'd0
    |-> ##4 out_res.result_bits == 32'd0) else $error("zero product wrong");
  a_busy: assert property (@(posedge clk) !busy) else $error("busy raised");
endmodule

bind float32_add_multiply_unit fpam_checker u_fpam_checker (.*);

// ===== verif/tb_top.sv =====
// Testbench for the single-precision add/multiply unit: directed table, then random requests.
module tb_top;
  import fpam_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_REQS  = 1400;
  localparam int SETTLE_LIMIT = 64;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  fpam_in_t  in_req;
  logic      out_valid;
  fpam_out_t out_res;

  fpam_out_t  pending_results[$];
  int         mismatches;
  int         results_seen;
  int         add_reqs;
  int         mul_reqs;
  int         flagged_results;

  // One row of the directed table; has_known marks rows with a typed-in answer
  typedef struct {
    fpam_in_t  req;
    logic      has_known;
    fpam_out_t known;
  } directed_row_t;

  directed_row_t directed_rows[$];

  float32_add_multiply_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop: far beyond the slowest correct run, including long gaps
  initial begin
    #20ms;
    $display("CHECKS FAILED");
    $finish;
  end

  // Pack sign, a signed exponent and a significand; flag the exponent when out of 0..255
  function automatic fpam_out_t pack_float(input logic sgn, input int expo,
                                           input logic [23:0] sig);
    fpam_out_t r;
    r.result_bits          = {sgn, expo[7:0], sig[22:0]};
    r.exponent_range_error = (expo < 0 || expo > 255);
    return r;
  endfunction

  // Truncating sum of two single-precision patterns
  function automatic fpam_out_t float_sum(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] big_op, small_op;
    logic [24:0] sig_sum;
    logic [23:0] sig_big, sig_small, sig_diff;
    int          exp_big, exp_small, shift, expo;
    fpam_out_t   r;
    r = '0;
    if (a == '0) begin
      r.result_bits = b;
      return r;
    end
    if (b == '0) begin
      r.result_bits = a;
      return r;
    end
    if (a[30:0] >= b[30:0]) begin
      big_op   = a;
      small_op = b;
    end else begin
      big_op   = b;
      small_op = a;
    end
    exp_big   = int'(big_op[30:23]);
    exp_small = int'(small_op[30:23]);
    sig_big   = {1'b1, big_op[22:0]};
    shift     = exp_big - exp_small;
    sig_small = (shift >= 24) ? 24'd0 : ({1'b1, small_op[22:0]} >> shift);
    if (big_op[31] == small_op[31]) begin
      sig_sum = {1'b0, sig_big} + {1'b0, sig_small};
      expo    = exp_big;
      if (sig_sum[24]) begin
        sig_sum = sig_sum >> 1;
        expo    = expo + 1;
      end
      return pack_float(big_op[31], expo, sig_sum[23:0]);
    end
    // Equal magnitudes of unlike sign cancel to plus zero
    if (big_op[30:0] == small_op[30:0]) return r;
    sig_diff = sig_big - sig_small;
    expo     = exp_big;
    while (!sig_diff[23] && sig_diff != '0) begin
      sig_diff = sig_diff << 1;
      expo     = expo - 1;
    end
    return pack_float(big_op[31], expo, sig_diff);
  endfunction

  // Truncating product of two single-precision patterns
  function automatic fpam_out_t float_product(input logic [31:0] a, input logic [31:0] b);
    logic [47:0] prod;
    int          expo;
    fpam_out_t   r;
    r = '0;
    if (a == '0 || b == '0) return r;
    expo = int'(a[30:23]) + int'(b[30:23]) - 127;
    prod = {24'd0, 1'b1, a[22:0]} * {24'd0, 1'b1, b[22:0]};
    if (prod[47]) return pack_float(a[31] ^ b[31], expo + 1, prod[47:24]);
    return pack_float(a[31] ^ b[31], expo, prod[46:23]);
  endfunction

  function automatic fpam_out_t float_result(input fpam_in_t req);
    return (req.func == FUNC_MUL) ? float_product(req.operand_a, req.operand_b)
                                  : float_sum(req.operand_a, req.operand_b);
  endfunction

  // Random operand: mostly moderate exponents so results stay in range, some raw patterns
  function automatic logic [31:0] rand_operand();
    logic [31:0] v;
    v = $urandom();
    case ($urandom_range(0, 9))
      0, 1:    v = $urandom();
      2:       v[30:23] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      3:       v = $urandom_range(0, 1) ? 32'h0 : 32'h8000_0000;
      default: v[30:23] = 8'($urandom_range(100, 154));
    endcase
    return v;
  endfunction

  task automatic add_row(input logic fn, input logic [31:0] a, input logic [31:0] b,
                         input logic known_valid, input logic [31:0] bits,
                         input logic flag);
    directed_row_t row;
    row.req       = '{func: fn, operand_a: a, operand_b: b};
    row.has_known = known_valid;
    row.known     = '{result_bits: bits, exponent_range_error: flag};
    directed_rows.push_back(row);
  endtask

  // Drive one request and hold it until accepted; the expectation is queued at acceptance
  task automatic send_request(input fpam_in_t req, input logic has_known,
                              input fpam_out_t known);
    start  <= 1'b1;
    in_req <= req;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_results.push_back(has_known ? known : float_result(req));
    if (req.func == FUNC_MUL) mul_reqs++;
    else add_reqs++;
  endtask

  // Random gap: mostly none, often short, now and then long
  task automatic sender_gap();
    int n;
    n = 0;
    case ($urandom_range(0, 19))
      0, 1, 2, 3, 4, 5: n = $urandom_range(1, 3);
      6:                n = $urandom_range(10, 40);
      default:          n = 0;
    endcase
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Compare each strobed result with the oldest expectation
  always @(posedge clk) begin
    fpam_out_t want;
    if (rst_n && out_valid) begin
      results_seen++;
      if (out_res.exponent_range_error) flagged_results++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result %h flag %b", out_res.result_bits,
                   out_res.exponent_range_error);
      end else begin
        want = pending_results.pop_front();
        if (want.result_bits !== out_res.result_bits ||
            want.exponent_range_error !== out_res.exponent_range_error) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %h flag %b, got %h flag %b",
                     want.result_bits, want.exponent_range_error,
                     out_res.result_bits, out_res.exponent_range_error);
        end
      end
    end
  end

  initial begin
    fpam_in_t req;
    int       waited;
    start      = 1'b0;
    in_req     = '0;
    rst_n      = 1'b0;
    mismatches = 0;
    results_seen = 0;
    add_reqs   = 0;
    mul_reqs   = 0;
    flagged_results = 0;

    // Known answers: zero operands, cancellation, plain sums and products, exponent wrap
    add_row(FUNC_ADD, 32'h0, 32'hDEAD_BEEF, 1'b1, 32'hDEAD_BEEF, 1'b0);
    add_row(FUNC_ADD, 32'h8000_0000, 32'h0, 1'b1, 32'h8000_0000, 1'b0);
    add_row(FUNC_ADD, 32'h0, 32'h0, 1'b1, 32'h0, 1'b0);
    add_row(FUNC_ADD, 32'h3F80_0000, 32'hBF80_0000, 1'b1, 32'h0, 1'b0);
    add_row(FUNC_ADD, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b1, 32'h0, 1'b0);
    add_row(FUNC_ADD, 32'h3F80_0000, 32'h3F80_0000, 1'b1, 32'h4000_0000, 1'b0);
    add_row(FUNC_ADD, 32'h7F80_0000, 32'h7F80_0000, 1'b1, 32'h0000_0000, 1'b1);
    add_row(FUNC_MUL, 32'h0, 32'hFFFF_FFFF, 1'b1, 32'h0, 1'b0);
    add_row(FUNC_MUL, 32'h8000_0000, 32'h0, 1'b1, 32'h0, 1'b0);
    add_row(FUNC_MUL, 32'h3F80_0000, 32'hBF80_0000, 1'b1, 32'hBF80_0000, 1'b0);
    add_row(FUNC_MUL, 32'h7F00_0000, 32'h7F00_0000, 1'b1, 32'h3E80_0000, 1'b1);
    add_row(FUNC_MUL, 32'h0080_0000, 32'h0080_0000, 1'b1, 32'h4180_0000, 1'b1);
    // Predicted rows: carry on equal exponents, far alignment, deep cancellation, raw patterns, products
    add_row(FUNC_ADD, 32'h3FFF_FFFF, 32'h3FFF_FFFF, 1'b0, '0, 1'b0);
    add_row(FUNC_ADD, 32'h4B80_0000, 32'h3F80_0000, 1'b0, '0, 1'b0);
    add_row(FUNC_ADD, 32'h3F80_0001, 32'hBF80_0000, 1'b0, '0, 1'b0);
    add_row(FUNC_ADD, 32'h0080_0001, 32'h8080_0000, 1'b0, '0, 1'b0);
    add_row(FUNC_ADD, 32'h7FFF_FFFF, 32'h0000_0001, 1'b0, '0, 1'b0);
    add_row(FUNC_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, '0, 1'b0);
    add_row(FUNC_MUL, 32'h3FFF_FFFF, 32'h3FFF_FFFF, 1'b0, '0, 1'b0);
    add_row(FUNC_MUL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, '0, 1'b0);
    add_row(FUNC_MUL, 32'h0000_0001, 32'h0000_0001, 1'b0, '0, 1'b0);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      send_request(directed_rows[i].req, directed_rows[i].has_known, directed_rows[i].known);
      sender_gap();
    end

    for (int i = 0; i < RANDOM_REQS; i++) begin
      req.func      = 1'($urandom_range(0, 1));
      req.operand_a = rand_operand();
      // Bias some requests towards close magnitudes to exercise cancellation
      if ($urandom_range(0, 4) == 0) begin
        req.operand_b = req.operand_a ^ {1'b1, 21'd0, 10'($urandom_range(0, 1023))};
      end else begin
        req.operand_b = rand_operand();
      end
      send_request(req, 1'b0, '0);
      sender_gap();
      // Hold off once until the pipeline has drained completely
      if (i == RANDOM_REQS / 2) begin
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
      end
    end
    start <= 1'b0;

    waited = 0;
    while (pending_results.size() != 0 && waited < 1000) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_LIMIT) @(posedge clk);

    $display("Covered %0d adds and %0d multiplies; %0d results, %0d with range flag.",
             add_reqs, mul_reqs, results_seen, flagged_results);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches, %0d results never arrived", mismatches,
               pending_results.size());
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
